/* rtl/core/aes_pkg.sv */
// shared types, constants and round functions for the aes-128 pipeline
package aes_pkg;

  localparam int unsigned NumRounds = 10;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic [3:0] REG_KEY_HIGH = 4'd0;
  localparam logic [3:0] REG_KEY_LOW  = 4'd1;

  typedef logic [127:0] block_t;
  typedef logic [127:0] rkey_t;

  // pipeline control that travels with each word
  typedef struct packed {
    logic valid;
    logic op;
  } stage_ctl_t;

  localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_BOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // multiply by x in gf(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the state sits at bits 127-8i
  function automatic logic [7:0] get_byte(input block_t s, input int unsigned i);
    get_byte = s[127 - 8*i -: 8];
  endfunction

  // next round key from the previous one
  function automatic rkey_t next_key(input rkey_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {FWD_BOX[w3[23:16]] ^ rc, FWD_BOX[w3[15:8]], FWD_BOX[w3[7:0]], FWD_BOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

  // forward sub bytes and shift rows
  function automatic block_t fwd_sub_shift(input block_t s);
    block_t t;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 8*(r + 4*c) -: 8] = FWD_BOX[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    fwd_sub_shift = t;
  endfunction

  // inverse shift rows and inverse sub bytes
  function automatic block_t inv_shift_sub(input block_t s);
    block_t t;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 8*(r + 4*((c + r) % 4)) -: 8] = INV_BOX[get_byte(s, r + 4*c)];
      end
    end
    inv_shift_sub = t;
  endfunction

  // forward mix columns
  function automatic block_t fwd_mix(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      t[127 - 32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[119 - 32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[111 - 32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[103 - 32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    fwd_mix = t;
  endfunction

  // inverse mix columns as a pre-step then forward mix
  function automatic block_t inv_mix(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, u, v;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      u = xtime(xtime(a0 ^ a2));
      v = xtime(xtime(a1 ^ a3));
      t[127 - 32*c -: 8] = a0 ^ u;
      t[119 - 32*c -: 8] = a1 ^ v;
      t[111 - 32*c -: 8] = a2 ^ u;
      t[103 - 32*c -: 8] = a3 ^ v;
    end
    inv_mix = fwd_mix(t);
  endfunction

endpackage

/* rtl/core/aes128_encrypt_decrypt.sv */
// aes-128 encrypt/decrypt top level: pipelined, one block per cycle while busy is low
// pipeline registers from start to done: one input stage plus ten rounds of two stages
// throughput: one block every cycle while busy is low; the receiver cannot stall, so done is never held
// round keys are rebuilt after reset or any key write, while cfg_write is low
// reset (rst, synchronous) clears the key to zero and empties the pipeline
// busy is high during key expansion after reset or a key write, else low
module aes128_encrypt_decrypt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  output logic        done,
  output logic [63:0] result_high,
  output logic [63:0] result_low,
  input  logic        cfg_write,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import aes_pkg::*;

  rkey_t      round_keys [NumRounds + 1];
  logic       keys_ready;
  stage_ctl_t ctl  [NumRounds + 1];
  block_t     st   [NumRounds + 1];

  aes_key_sched u_keys (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .round_keys (round_keys),
    .keys_ready (keys_ready)
  );

  // input stage: initial key addition for the chosen direction
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid <= 1'b0;
    end else begin
      ctl[0].valid <= start && !busy;
    end
    ctl[0].op <= operation;
    st[0]     <= {block_high, block_low} ^
                 ((operation == OP_DECRYPT) ? round_keys[NumRounds] : round_keys[0]);
  end

  // ten rounds; decrypt uses keys in reverse order
  for (genvar g = 1; g <= NumRounds; g++) begin : g_round
    aes_round u_round (
      .clk       (clk),
      .rst       (rst),
      .last      (g == NumRounds),
      .ctl_in    (ctl[g-1]),
      .state_in  (st[g-1]),
      .enc_key   (round_keys[g]),
      .dec_key   (round_keys[NumRounds - g]),
      .ctl_out   (ctl[g]),
      .state_out (st[g])
    );
  end

  assign busy        = !keys_ready;
  assign done        = ctl[NumRounds].valid;
  assign result_high = st[NumRounds][127:64];
  assign result_low  = st[NumRounds][63:0];

`ifndef SYNTHESIS
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    ctl[0].valid |=> ##(2*NumRounds - 1) done)
    else $error("accepted word did not complete");
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2*NumRounds + 1))
    else $error("result without an accepted word");
  a_busy_after_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW)) |=> busy)
    else $error("accepting words during key expansion");
`endif
endmodule

/* rtl/core/aes_key_sched.sv */
// round key schedule held in registers, recomputed one key per cycle while cfg_write is low after reset or a key write
module aes_key_sched (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [3:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  output aes_pkg::rkey_t round_keys [aes_pkg::NumRounds + 1],
  output logic          keys_ready
);
  import aes_pkg::*;

  localparam int unsigned CntW = $clog2(NumRounds + 1);

  logic [63:0] key_high;
  logic [63:0] key_low;
  rkey_t       keys [NumRounds + 1];
  logic [CntW-1:0] fill;

  // key registers and incremental expansion, one round key per cycle while cfg_write is low
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      fill     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KEY_HIGH: begin
          key_high <= cfg_data;
          fill     <= '0;
        end
        REG_KEY_LOW: begin
          key_low <= cfg_data;
          fill    <= '0;
        end
        default: ;
      endcase
    end else if (fill == '0) begin
      keys[0] <= {key_high, key_low};
      fill    <= CntW'(1);
    end else if (fill <= CntW'(NumRounds)) begin
      keys[fill] <= next_key(keys[fill - CntW'(1)], RCON[fill - CntW'(1)]);
      fill       <= fill + CntW'(1);
    end
  end

  assign round_keys = keys;
  assign keys_ready = (fill == CntW'(NumRounds + 1));

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= CntW'(NumRounds + 1))
    else $error("key fill count out of range");
  a_write_restarts: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW)) |=> !keys_ready)
    else $error("key write did not restart expansion");
  a_first_key: assert property (@(posedge clk) disable iff (rst)
    (keys_ready && !$past(cfg_write)) |-> keys[0] == {key_high, key_low})
    else $error("first round key differs from key");
`endif
endmodule

/* rtl/core/aes_round.sv */
// one pipelined cipher round in two register stages, direction chosen per word
module aes_round (
  input  logic              clk,
  input  logic              rst,
  input  logic              last,
  input  aes_pkg::stage_ctl_t ctl_in,
  input  aes_pkg::block_t   state_in,
  input  aes_pkg::rkey_t    enc_key,
  input  aes_pkg::rkey_t    dec_key,
  output aes_pkg::stage_ctl_t ctl_out,
  output aes_pkg::block_t   state_out
);
  import aes_pkg::*;

  stage_ctl_t ctl_mid;
  block_t     mid;
  block_t     mid_next;
  block_t     out_next;

  // first half: byte substitution and row shift, key added early on decrypt
  always_comb begin
    if (ctl_in.op == OP_DECRYPT) begin
      mid_next = inv_shift_sub(state_in) ^ dec_key;
    end else begin
      mid_next = fwd_sub_shift(state_in);
    end
  end

  // second half: column mix unless this is the final round, key added here on encrypt
  always_comb begin
    if (ctl_mid.op == OP_DECRYPT) begin
      out_next = last ? mid : inv_mix(mid);
    end else begin
      out_next = (last ? mid : fwd_mix(mid)) ^ enc_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_mid.valid <= 1'b0;
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_mid.valid <= ctl_in.valid;
      ctl_out.valid <= ctl_mid.valid;
    end
    ctl_mid.op <= ctl_in.op;
    ctl_out.op <= ctl_mid.op;
    mid        <= mid_next;
    state_out  <= out_next;
  end

`ifndef SYNTHESIS
  a_valid_flow: assert property (@(posedge clk) disable iff (rst)
    ctl_in.valid |=> ##1 ctl_out.valid)
    else $error("word lost inside round");
  a_op_flow: assert property (@(posedge clk) disable iff (rst)
    ctl_in.valid |=> ##1 (ctl_out.op == $past(ctl_in.op, 2)))
    else $error("direction changed inside round");
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    ctl_out.valid |-> $past(ctl_in.valid, 2))
    else $error("round produced a word from nothing");
`endif
endmodule

/* sim/testbench.sv */
// self-checking testbench for the aes-128 encrypt/decrypt pipeline
module testbench;
  import aes_pkg::*;

  typedef struct {
    logic        op;
    logic [63:0] hi;
    logic [63:0] lo;
  } word_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        operation = OP_ENCRYPT;
  logic [63:0] block_high = '0;
  logic [63:0] block_low = '0;
  logic        done;
  logic [63:0] result_high;
  logic [63:0] result_low;
  logic        cfg_write = 1'b0;
  logic [3:0]  cfg_index = REG_KEY_HIGH;
  logic [63:0] cfg_data = '0;

  word_t       pending_words[$];
  cipher_out_t expected_results[$];
  logic [63:0] model_key_high = '0;
  logic [63:0] model_key_low = '0;
  bit          steady = 1'b0;
  int          fails = 0;
  int          quiet_cycles = 0;

  aes128_encrypt_decrypt uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .block_high(block_high), .block_low(block_low), .done(done),
    .result_high(result_high), .result_low(result_low),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // gf(2^8) product with a small constant
  function automatic logic [7:0] gf_product(logic [7:0] a, logic [3:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      if (b[k]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  // byte substitution together with the row rotation
  function automatic logic [127:0] rows_and_box(logic [127:0] s, bit inv);
    logic [127:0] t;
    int src, dst;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = r + 4 * ((c + r) % 4);
        dst = r + 4 * c;
        if (inv) t[127 - 8*src -: 8] = INV_BOX[s[127 - 8*dst -: 8]];
        else t[127 - 8*dst -: 8] = FWD_BOX[s[127 - 8*src -: 8]];
      end
    end
    return t;
  endfunction

  // column mixing, forward or inverse matrix
  function automatic logic [127:0] mix_columns(logic [127:0] s, bit inv);
    logic [127:0] t;
    logic [3:0] coef[4];
    logic [7:0] v;
    if (inv) coef = '{4'he, 4'hb, 4'hd, 4'h9};
    else coef = '{4'h2, 4'h3, 4'h1, 4'h1};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        v = '0;
        for (int k = 0; k < 4; k++) v ^= gf_product(s[127 - 8*(4*c + k) -: 8], coef[(k + 4 - r) % 4]);
        t[127 - 8*(4*c + r) -: 8] = v;
      end
    end
    return t;
  endfunction

  // full aes-128 transform of one block under the given key
  function automatic logic [127:0] cipher_model(logic op, logic [127:0] key, logic [127:0] blk);
    logic [31:0] w[44];
    logic [31:0] t;
    logic [127:0] rk[11];
    logic [127:0] s;
    for (int i = 0; i < 4; i++) w[i] = key[127 - 32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {FWD_BOX[t[31:24]] ^ RCON[i/4 - 1], FWD_BOX[t[23:16]], FWD_BOX[t[15:8]],
             FWD_BOX[t[7:0]]};
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    s = blk;
    if (op == OP_ENCRYPT) begin
      s ^= rk[0];
      for (int r = 1; r < 10; r++) s = mix_columns(rows_and_box(s, 1'b0), 1'b0) ^ rk[r];
      s = rows_and_box(s, 1'b0) ^ rk[10];
    end else begin
      s ^= rk[10];
      for (int r = 9; r >= 1; r--) s = mix_columns(rows_and_box(s, 1'b1) ^ rk[r], 1'b1);
      s = rows_and_box(s, 1'b1) ^ rk[0];
    end
    return s;
  endfunction

  // driver: predict on acceptance, then present the next word
  always @(posedge clk) begin
    logic [127:0] res;
    word_t nxt;
    if (!rst) begin
      if (start && !busy) begin
        res = cipher_model(operation, {model_key_high, model_key_low}, {block_high, block_low});
        expected_results.push_back('{res[127:64], res[63:0]});
      end
      if (!start || !busy) begin
        if (pending_words.size() > 0 && (steady || $urandom_range(99) >= 17)) begin
          nxt = pending_words.pop_front();
          start <= 1'b1;
          operation <= nxt.op;
          block_high <= nxt.hi;
          block_low <= nxt.lo;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    cipher_out_t exp_r;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result %h %h", result_high, result_low);
        fails++;
      end else begin
        exp_r = expected_results.pop_front();
        if (result_high !== exp_r.hi) begin
          $error("result_high expected %h actual %h", exp_r.hi, result_high);
          fails++;
        end
        if (result_low !== exp_r.lo) begin
          $error("result_low expected %h actual %h", exp_r.lo, result_low);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // random bytes biased toward 00 and ff
  function automatic logic [63:0] edgy64();
    logic [63:0] v;
    int p;
    for (int i = 0; i < 8; i++) begin
      p = $urandom_range(2);
      v[8*i +: 8] = (p == 0) ? 8'h00 : (p == 1) ? 8'hff : 8'($urandom());
    end
    return v;
  endfunction

  task automatic add_word(logic op, logic [63:0] hi, logic [63:0] lo);
    pending_words.push_back('{op, hi, lo});
  endtask

  // register write; caller drops cfg_write after the last one
  task automatic write_reg(logic [3:0] idx, logic [63:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_KEY_HIGH) model_key_high = val;
    else if (idx == REG_KEY_LOW) model_key_low = val;
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && !start && expected_results.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_key(logic [63:0] hi, logic [63:0] lo);
    write_reg(REG_KEY_HIGH, hi);
    write_reg(REG_KEY_LOW, lo);
    cfg_write <= 1'b0;
    repeat (15) @(posedge clk);
  endtask

  task automatic random_words(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) add_word(1'($urandom()), edgy64(), edgy64());
      else add_word(1'($urandom()), rand64(), rand64());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (15) @(posedge clk);

    // key never written: all-zero key
    add_word(OP_ENCRYPT, '0, '0);
    add_word(OP_DECRYPT, '0, '0);
    add_word(OP_ENCRYPT, '1, '1);
    add_word(OP_DECRYPT, '1, '1);
    add_word(OP_ENCRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    drain();

    // writes to unknown indexes must leave the key alone
    write_reg(4'd2, '1);
    write_reg(4'd15, 64'h0123456789abcdef);
    cfg_write <= 1'b0;
    repeat (15) @(posedge clk);
    add_word(OP_ENCRYPT, 64'h0123456789abcdef, '0);
    add_word(OP_DECRYPT, '0, 64'h0123456789abcdef);
    drain();

    // standard vector key, encrypt and decrypt
    set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    add_word(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    add_word(OP_DECRYPT, 64'h69c4e055dbd8cd6b, 64'h7b7bf8c3b4a5a6ba);
    add_word(OP_ENCRYPT, '1, '0);
    add_word(OP_DECRYPT, '0, '1);
    random_words(150);
    drain();

    // all-ones key, back to back with no gaps
    set_key('1, '1);
    steady = 1'b1;
    add_word(OP_ENCRYPT, '0, '0);
    add_word(OP_DECRYPT, '1, '1);
    random_words(150);
    drain();
    steady = 1'b0;

    // a few random keys, including one half zero
    set_key('0, rand64());
    random_words(150);
    drain();
    for (int k = 0; k < 3; k++) begin
      set_key(rand64(), rand64());
      random_words(150);
      drain();
    end

    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/aes_pkg.sv
rtl/core/aes_key_sched.sv
rtl/core/aes_round.sv
rtl/core/aes128_encrypt_decrypt.sv
sim/testbench.sv
